@@ rtl/mie_pkg.sv @@
// Shared types and constants for the MIPS-I integer execute block.
// Holds opcode and function codes, status codes and controller/datapath structs.
// No dependencies.
package mie_pkg;

  // Data memory geometry.
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // Divider step count (one quotient bit per cycle).
  localparam logic [5:0] DIV_STEPS = 6'd32;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_SYSCALL = 3'd3;
  localparam logic [2:0] ST_COP     = 3'd4;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_COP3    = 6'h13;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;

  // SPECIAL function codes.
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // REGIMM rt codes.
  localparam logic [4:0] RI_BLTZ = 5'd0;
  localparam logic [4:0] RI_BGEZ = 5'd1;

  // COP0 rs codes that are reported rather than rejected.
  localparam logic [4:0] CO_MF = 5'h00;
  localparam logic [4:0] CO_MT = 5'h04;
  localparam logic [4:0] CO_CO = 5'h10;

  // Link register for jal.
  localparam logic [4:0] REG_RA = 5'd31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } mie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_op;
    logic div_busy;
  } mie_sts_t;

endpackage

@@ rtl/mie_req_if.sv @@
// Input channel of the execute block: valid/ready handshake with the item payload.
// Depends on nothing.
interface mie_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] instruction;
  logic [31:0] pc;
  logic [11:0] preload_index;
  logic [31:0] preload_word;

  modport source (output valid, command, instruction, pc, preload_index, preload_word,
                  input ready);
  modport sink   (input valid, command, instruction, pc, preload_index, preload_word,
                  output ready);
endinterface

@@ rtl/mie_rsp_if.sv @@
// Output channel of the execute block: valid/ready handshake with the result payload.
// Depends on nothing.
interface mie_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [31:0] next_pc;
  logic        branch_taken;
  logic        store_valid;
  logic [31:0] store_address;
  logic [31:0] store_word;
  logic [31:0] hi_value;
  logic [31:0] lo_value;

  modport source (output valid, status, reg_write, reg_index, reg_value, next_pc,
                  branch_taken, store_valid, store_address, store_word, hi_value,
                  lo_value, input ready);
  modport sink   (input valid, status, reg_write, reg_index, reg_value, next_pc,
                  branch_taken, store_valid, store_address, store_word, hi_value,
                  lo_value, output ready);
endinterface

@@ rtl/mie_div.sv @@
// Iterative restoring divider for unsigned 32-bit operands, one quotient bit per cycle.
// Depends on mie_pkg.
module mie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  import mie_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  // Control: start loads the step counter with DIV_STEPS and sets busy; busy clears when the count runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_STEPS;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: one restoring step per cycle while busy.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ rtl/mie_dp.sv @@
// Datapath of the execute block: register file, HI/LO, data memory, multiplier,
// divider and the execute logic. Depends on mie_pkg and mie_div.
module mie_dp (
  input  logic               clk,
  input  logic               rst,
  input  mie_pkg::mie_cmd_t  cmd,
  output mie_pkg::mie_sts_t  sts,
  input  logic               command,
  input  logic [31:0]        instruction,
  input  logic [31:0]        pc,
  input  logic [11:0]        preload_index,
  input  logic [31:0]        preload_word,
  output logic [2:0]         status,
  output logic               reg_write,
  output logic [4:0]         reg_index,
  output logic [31:0]        reg_value,
  output logic [31:0]        next_pc,
  output logic               branch_taken,
  output logic               store_valid,
  output logic [31:0]        store_address,
  output logic [31:0]        store_word,
  output logic [31:0]        hi_value,
  output logic [31:0]        lo_value
);
  import mie_pkg::*;

  // Latched transaction.
  logic        cmd_r;
  logic [31:0] ins_r;
  logic [31:0] pc_r;
  logic [11:0] pidx_r;
  logic [31:0] pword_r;

  // Architectural state.
  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] hi;
  logic [31:0] lo;

  // Registered operands, memory word and product.
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] mw;
  logic [63:0] prod;

  // Instruction fields.
  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] ea;
  logic [31:0] btgt;
  logic [4:0]  lane;
  logic [4:0]  hlane;
  logic [4:0]  lsh;
  logic [MEM_AW-1:0] slot;

  // Divider signals.
  logic        na;
  logic        nb;
  logic        is_signed_div;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_busy;
  logic [31:0] div_q;
  logic [31:0] div_r;

  // Execute results.
  logic [2:0]  st;
  logic        wr;
  logic [4:0]  wi;
  logic [31:0] wv;
  logic [31:0] npc;
  logic        tk;
  logic        sv;
  logic [31:0] sw;
  logic [31:0] hi_next;
  logic [31:0] lo_next;
  logic        cond;
  logic        is_branch;
  logic [31:0] m;

  assign op    = ins_r[31:26];
  assign rs    = ins_r[25:21];
  assign rt    = ins_r[20:16];
  assign rd    = ins_r[15:11];
  assign sh    = ins_r[10:6];
  assign fn    = ins_r[5:0];
  assign imm   = ins_r[15:0];
  assign simm  = {{16{imm[15]}}, imm};
  assign ea    = a + simm;
  assign btgt  = pc_r + 32'd4 + {simm[29:0], 2'b00};
  assign lane  = {ea[1:0], 3'b000};
  assign hlane = {ea[1], 4'b0000};
  assign lsh   = 5'd24 - lane;
  assign slot  = ea[2 +: MEM_AW];

  // Transaction latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= command;
      ins_r   <= instruction;
      pc_r    <= pc;
      pidx_r  <= preload_index;
      pword_r <= preload_word;
    end
  end

  // Register file read, registered; entries never written read as zero.
  always_ff @(posedge clk) begin
    a <= rf_valid[rs] ? rf[rs] : 32'd0;
    b <= rf_valid[rt] ? rf[rt] : 32'd0;
  end

  // Register file write and its valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (cmd.commit && wr) begin
      rf_valid[wi] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr) begin
      rf[wi] <= wv;
    end
  end

  // Data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && cmd_r) begin
      mem[MEM_AW'(pidx_r)] <= pword_r;
    end else if (cmd.commit && sv) begin
      mem[slot] <= sw;
    end
    mw <= mem[slot];
  end

  // Unsigned multiplier, registered product.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Divider operand preparation on magnitudes for the signed form.
  assign is_signed_div = (fn == FN_DIV);
  assign na    = is_signed_div & a[31];
  assign nb    = is_signed_div & b[31];
  assign div_a = na ? (32'd0 - a) : a;
  assign div_b = nb ? (32'd0 - b) : b;

  mie_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign sts.div_busy = div_busy;
  assign sts.div_op   = !cmd_r && (op == OP_SPECIAL) && ((fn == FN_DIV) || (fn == FN_DIVU))
                        && (b != 32'd0);

  // Execute: decode the instruction and form every result of the transaction.
  always_comb begin
    st        = ST_OK;
    wr        = 1'b0;
    wi        = '0;
    wv        = '0;
    npc       = pc_r + 32'd4;
    tk        = 1'b0;
    sv        = 1'b0;
    sw        = '0;
    hi_next   = hi;
    lo_next   = lo;
    cond      = 1'b0;
    is_branch = 1'b0;
    m         = '0;
    if (cmd_r) begin
      npc = '0;
    end else if (ins_r != 32'd0) begin
      unique case (op)
        OP_SPECIAL: begin
          unique case (fn)
            FN_SLL:  begin wr = 1'b1; wi = rd; wv = b << sh; end
            FN_SRL:  begin wr = 1'b1; wi = rd; wv = b >> sh; end
            FN_SRA:  begin wr = 1'b1; wi = rd; wv = $unsigned($signed(b) >>> sh); end
            FN_SLLV: begin wr = 1'b1; wi = rd; wv = b << a[4:0]; end
            FN_SRLV: begin wr = 1'b1; wi = rd; wv = b >> a[4:0]; end
            FN_SRAV: begin wr = 1'b1; wi = rd; wv = $unsigned($signed(b) >>> a[4:0]); end
            FN_JR:   begin npc = a; tk = 1'b1; end
            FN_JALR: begin
              npc = a; tk = 1'b1; wr = 1'b1; wi = rd; wv = pc_r + 32'd8;
            end
            FN_SYSCALL: st = ST_SYSCALL;
            FN_MFHI: begin wr = 1'b1; wi = rd; wv = hi; end
            FN_MTHI: hi_next = a;
            FN_MFLO: begin wr = 1'b1; wi = rd; wv = lo; end
            FN_MTLO: lo_next = a;
            FN_MULTU: begin lo_next = prod[31:0]; hi_next = prod[63:32]; end
            FN_DIV, FN_DIVU: begin
              if (b == 32'd0) begin
                st = ST_DIVZERO;
              end else begin
                lo_next = (na != nb) ? (32'd0 - div_q) : div_q;
                hi_next = na ? (32'd0 - div_r) : div_r;
              end
            end
            FN_ADD, FN_ADDU: begin wr = 1'b1; wi = rd; wv = a + b; end
            FN_SUBU: begin wr = 1'b1; wi = rd; wv = a - b; end
            FN_AND:  begin wr = 1'b1; wi = rd; wv = a & b; end
            FN_OR:   begin wr = 1'b1; wi = rd; wv = a | b; end
            FN_XOR:  begin wr = 1'b1; wi = rd; wv = a ^ b; end
            FN_NOR:  begin wr = 1'b1; wi = rd; wv = ~(a | b); end
            FN_SLT:  begin wr = 1'b1; wi = rd; wv = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin wr = 1'b1; wi = rd; wv = {31'd0, a < b}; end
            default: st = ST_UNKNOWN;
          endcase
        end
        OP_REGIMM: begin
          if (rt == RI_BLTZ) begin
            is_branch = 1'b1; cond = a[31];
          end else if (rt == RI_BGEZ) begin
            is_branch = 1'b1; cond = !a[31];
          end else begin
            st = ST_UNKNOWN;
          end
        end
        OP_J, OP_JAL: begin
          npc = {npc[31:28], ins_r[25:0], 2'b00};
          tk  = 1'b1;
          if (op == OP_JAL) begin
            wr = 1'b1; wi = REG_RA; wv = pc_r + 32'd8;
          end
        end
        OP_BEQ:  begin is_branch = 1'b1; cond = (a == b); end
        OP_BNE:  begin is_branch = 1'b1; cond = (a != b); end
        OP_BLEZ: begin is_branch = 1'b1; cond = a[31] || (a == 32'd0); end
        OP_BGTZ: begin is_branch = 1'b1; cond = !a[31] && (a != 32'd0); end
        OP_ADDI, OP_ADDIU: begin wr = 1'b1; wi = rt; wv = a + simm; end
        OP_SLTI:  begin wr = 1'b1; wi = rt; wv = {31'd0, $signed(a) < $signed(simm)}; end
        OP_SLTIU: begin wr = 1'b1; wi = rt; wv = {31'd0, a < simm}; end
        OP_ANDI:  begin wr = 1'b1; wi = rt; wv = a & {16'd0, imm}; end
        OP_ORI:   begin wr = 1'b1; wi = rt; wv = a | {16'd0, imm}; end
        OP_LUI:   begin wr = 1'b1; wi = rt; wv = {imm, 16'd0}; end
        OP_COP0, OP_COP1, OP_COP2, OP_COP3: begin
          st = ((op == OP_COP0) && ((rs == CO_MF) || (rs == CO_MT) || (rs == CO_CO)))
               ? ST_COP : ST_UNKNOWN;
        end
        OP_LB: begin
          wr = 1'b1; wi = rt; m = mw >> lane; wv = {{24{m[7]}}, m[7:0]};
        end
        OP_LH: begin
          wr = 1'b1; wi = rt; m = mw >> hlane; wv = {{16{m[15]}}, m[15:0]};
        end
        OP_LWL: begin
          m = 32'hFFFF_FFFF << lsh;
          wr = 1'b1; wi = rt; wv = (b & ~m) | ((mw << lsh) & m);
        end
        OP_LW:  begin wr = 1'b1; wi = rt; wv = mw; end
        OP_LBU: begin wr = 1'b1; wi = rt; m = mw >> lane; wv = {24'd0, m[7:0]}; end
        OP_LHU: begin wr = 1'b1; wi = rt; m = mw >> hlane; wv = {16'd0, m[15:0]}; end
        OP_LWR: begin
          m = 32'hFFFF_FFFF >> lane;
          wr = 1'b1; wi = rt; wv = (b & ~m) | ((mw >> lane) & m);
        end
        OP_SB: begin
          sv = 1'b1; sw = (mw & ~(32'h0000_00FF << lane)) | ({24'd0, b[7:0]} << lane);
        end
        OP_SH: begin
          sv = 1'b1; sw = (mw & ~(32'h0000_FFFF << hlane)) | ({16'd0, b[15:0]} << hlane);
        end
        OP_SWL: begin
          m = 32'hFFFF_FFFF >> lsh;
          sv = 1'b1; sw = (mw & ~m) | (b >> lsh);
        end
        OP_SW: begin sv = 1'b1; sw = b; end
        OP_SWR: begin
          m = 32'hFFFF_FFFF << lane;
          sv = 1'b1; sw = (mw & ~m) | (b << lane);
        end
        default: st = ST_UNKNOWN;
      endcase
      if (is_branch && cond) begin
        npc = btgt;
        tk  = 1'b1;
      end
      // A write to register zero is dropped.
      if (wr && (wi == 5'd0)) begin
        wr = 1'b0;
      end
    end
    if (!wr) begin
      wi = '0;
      wv = '0;
    end
  end

  // HI/LO update.
  always_ff @(posedge clk) begin
    if (rst) begin
      hi <= '0;
      lo <= '0;
    end else if (cmd.commit) begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= st;
      reg_write     <= wr;
      reg_index     <= wi;
      reg_value     <= wv;
      next_pc       <= npc;
      branch_taken  <= tk;
      store_valid   <= sv;
      store_address <= sv ? ea : 32'd0;
      store_word    <= sw;
      hi_value      <= hi_next;
      lo_value      <= lo_next;
    end
  end

endmodule

@@ rtl/mie_ctrl.sv @@
// Controller of the execute block: sequences register read, memory read,
// divide and commit, and owns both channel handshakes. Depends on mie_pkg.
module mie_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mie_pkg::mie_cmd_t cmd,
  input  mie_pkg::mie_sts_t sts
);
  import mie_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDREG = 3'd1;
  localparam logic [2:0] S_MEMRD = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RDREG;
        end
      end
      S_RDREG: state_next = S_MEMRD;
      S_MEMRD: begin
        if (sts.div_op) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction always moves on to the register read.
  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RDREG))
    else $error("accepted transaction did not start register read");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit overwrote a pending result");

  // Starting the divider makes it busy on the next cycle.
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

  // The divider is idle whenever a transaction is committed.
  a_div_idle_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.div_busy)
    else $error("commit while divider busy");
`endif

endmodule

@@ rtl/mips1_integer_execute_top.sv @@
// MIPS-I integer execute block. Each transaction either preloads one data memory
// word or executes one instruction. A transaction passes through the accept cycle,
// register file read, data memory read and multiply, then execute and commit. The
// result is registered at commit and then offered, and the next transaction is
// accepted in the cycle after commit, so no transaction is taken before the last
// one is committed. Commit waits while an earlier result has not been taken.
// div and divu with a nonzero divisor also pass through a divide state for the
// one-bit-per-cycle divider. The data memory holds 4096 words, little-endian,
// and a load from a word never written since reset returns an unspecified value.
// Depends on mie_pkg, mie_req_if, mie_rsp_if, mie_ctrl, mie_dp and mie_div.
module mips1_integer_execute_top (
  input logic        clk,
  input logic        rst,
  mie_req_if.sink    req,
  mie_rsp_if.source  rsp
);
  import mie_pkg::*;

  mie_cmd_t cmd;
  mie_sts_t sts;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mie_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .command       (req.command),
    .instruction   (req.instruction),
    .pc            (req.pc),
    .preload_index (req.preload_index),
    .preload_word  (req.preload_word),
    .status        (rsp.status),
    .reg_write     (rsp.reg_write),
    .reg_index     (rsp.reg_index),
    .reg_value     (rsp.reg_value),
    .next_pc       (rsp.next_pc),
    .branch_taken  (rsp.branch_taken),
    .store_valid   (rsp.store_valid),
    .store_address (rsp.store_address),
    .store_word    (rsp.store_word),
    .hi_value      (rsp.hi_value),
    .lo_value      (rsp.lo_value)
  );

endmodule
